>>> rtl/fchg_pkg.sv
// Package for the fan curve hysteresis governor: field widths, register
// indexes, reset values, event codes and the sequencer microcode table.
// No dependencies; every other file imports it.
package fchg_pkg;

    // Field widths
    localparam int TEMP_W    = 8;
    localparam int PATTERN_W = 8;
    localparam int TARGET_W  = 7;
    localparam int STAGE_W   = 3;
    localparam int EVENT_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int POINTS_W  = 4;
    localparam int HYST_W    = 5;
    localparam int PAIR_W    = 16;

    // Curve limits
    localparam int MAX_POINTS     = 8;
    localparam int TARGET_MIN     = 1;
    localparam int TARGET_MAX     = 110;
    localparam int FAIL_LIMIT_DEF = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_UP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_TARGET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_PATTERN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_POINTS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ON_THRESHOLD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_THRESHOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_PAIR  = 3'd7;

    // Register reset values
    localparam logic [HYST_W-1:0]  HYST_RST = 5'd4;
    localparam logic [TEMP_W-1:0]  ON_RST   = 8'd55;
    localparam logic [TEMP_W-1:0]  OFF_RST  = 8'd45;
    localparam logic [PAIR_W-1:0]  PAIR_RST = 16'd256;

    // Result event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 3'd0,
        EV_INIT   = 3'd1,
        EV_HOLD   = 3'd2,
        EV_CHANGE = 3'd3,
        EV_TOGGLE = 3'd4,
        EV_FAIL   = 3'd5
    } event_t;

    // Microcode
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_CLAMP,
        OP_CLIMB,
        OP_DESCEND,
        OP_CURVE_UPD,
        OP_THRESH_UPD,
        OP_FAIL_UPD,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_NOT_OK,
        C_NO_CURVE,
        C_STEP,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    // Step addresses
    localparam pc_t S_WAIT     = 4'd0;
    localparam pc_t S_CHECK_OK = 4'd1;
    localparam pc_t S_MODE     = 4'd2;
    localparam pc_t S_CLAMP    = 4'd3;
    localparam pc_t S_CLIMB    = 4'd4;
    localparam pc_t S_DESCEND  = 4'd5;
    localparam pc_t S_CURVE    = 4'd6;
    localparam pc_t S_THRESH   = 4'd7;
    localparam pc_t S_FAIL     = 4'd8;
    localparam pc_t S_EMIT     = 4'd9;
    localparam pc_t S_RETRY    = 4'd10;

    // Program: a jump is taken when its condition holds, else the next step runs
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        unique case (pc)
            S_WAIT:     w = '{OP_LATCH,      C_NO_INPUT, S_WAIT};
            S_CHECK_OK: w = '{OP_NOP,        C_NOT_OK,   S_FAIL};
            S_MODE:     w = '{OP_NOP,        C_NO_CURVE, S_THRESH};
            S_CLAMP:    w = '{OP_CLAMP,      C_NEVER,    S_WAIT};
            S_CLIMB:    w = '{OP_CLIMB,      C_STEP,     S_CLIMB};
            S_DESCEND:  w = '{OP_DESCEND,    C_STEP,     S_DESCEND};
            S_CURVE:    w = '{OP_CURVE_UPD,  C_ALWAYS,   S_EMIT};
            S_THRESH:   w = '{OP_THRESH_UPD, C_ALWAYS,   S_EMIT};
            S_FAIL:     w = '{OP_FAIL_UPD,   C_NEVER,    S_WAIT};
            S_EMIT:     w = '{OP_EMIT,       C_OUT_FREE, S_WAIT};
            S_RETRY:    w = '{OP_NOP,        C_ALWAYS,   S_EMIT};
            default:    w = '{OP_NOP,        C_ALWAYS,   S_WAIT};
        endcase
        return w;
    endfunction

    // Byte i of a packed 64-bit curve register
    function automatic logic [7:0] byte_sel(input logic [CFG_DATA_W-1:0] w,
                                            input logic [STAGE_W-1:0] i);
        return w[{i, 3'b000} +: 8];
    endfunction

endpackage

>>> rtl/fchg_if.sv
// Valid/ready channel interfaces for the fan curve governor: temperature
// polls in, governor results out. Depends on fchg_pkg for field widths.
interface fchg_poll_if
    import fchg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] temperature;
    logic              reading_ok;

    modport source (output valid, output temperature, output reading_ok, input ready);
    modport sink   (input valid, input temperature, input reading_ok, output ready);
endinterface

interface fchg_result_if
    import fchg_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [PATTERN_W-1:0] fan_pattern;
    logic [TARGET_W-1:0]  target_temperature;
    logic [STAGE_W-1:0]   stage;
    logic                 fan_running;
    logic [EVENT_W-1:0]   event_res;
    logic                 apply_pattern;
    logic                 apply_target;

    modport source (output valid, output fan_pattern, output target_temperature,
                    output stage, output fan_running, output event_res,
                    output apply_pattern, output apply_target, input ready);
    modport sink   (input valid, input fan_pattern, input target_temperature,
                    input stage, input fan_running, input event_res,
                    input apply_pattern, input apply_target, output ready);
endinterface

>>> rtl/fan_curve_hysteresis_governor.sv
// Stepped fan curve governor with hysteresis, run by a microcoded sequencer.
// Depends on fchg_pkg (microcode, codes, widths) and fchg_if (channels).
//
//   channel  | dir | beat contents
//   ---------+-----+-----------------------------------------------------------
//   poll     | in  | temperature, reading_ok
//   result   | out | fan_pattern, target_temperature, stage, fan_running,
//            |     | event_res, apply_pattern, apply_target
//   wr_*     | in  | wr_en, wr_index, wr_data (register write, no handshake)
//
// One poll at a time. An accepted poll is latched and checked; a failed read
// then runs the fail step, threshold mode the threshold step, and curve mode
// the clamp, climb, descend and curve steps, each path ending at the emit
// step. Climb and descend repeat while their stage compare holds.
// The result sits in an output register, so the next poll is taken while it
// waits; a stalled output register loops the sequencer through emit and retry.
// rst_n asynchronously resets control state and config, not payload regs.
module fan_curve_hysteresis_governor
    import fchg_pkg::*;
#(
    parameter int FAIL_LIMIT = FAIL_LIMIT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    fchg_poll_if.sink             poll,
    fchg_result_if.source         result,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    localparam int FCW = $clog2(FAIL_LIMIT + 1);
    localparam logic [FCW-1:0] FAIL_MAX = FCW'(FAIL_LIMIT);

    // Configuration registers
    logic [CFG_DATA_W-1:0] curve_up_reg, curve_tgt_reg, curve_pat_reg;
    logic [POINTS_W-1:0]   points_reg;
    logic [HYST_W-1:0]     hyst_reg;
    logic [TEMP_W-1:0]     on_reg, off_reg;
    logic [PAIR_W-1:0]     pair_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_up_reg  <= '0;
            curve_tgt_reg <= '0;
            curve_pat_reg <= '0;
            points_reg    <= '0;
            hyst_reg      <= HYST_RST;
            on_reg        <= ON_RST;
            off_reg       <= OFF_RST;
            pair_reg      <= PAIR_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CURVE_UP:      curve_up_reg  <= wr_data;
                REG_CURVE_TARGET:  curve_tgt_reg <= wr_data;
                REG_CURVE_PATTERN: curve_pat_reg <= wr_data;
                REG_CURVE_POINTS:  points_reg    <= wr_data[POINTS_W-1:0];
                REG_HYSTERESIS:    hyst_reg      <= wr_data[HYST_W-1:0];
                REG_ON_THRESHOLD:  on_reg        <= wr_data[TEMP_W-1:0];
                REG_OFF_THRESHOLD: off_reg       <= wr_data[TEMP_W-1:0];
                REG_PATTERN_PAIR:  pair_reg      <= wr_data[PAIR_W-1:0];
                default:           ;
            endcase
        end
    end

    // Derived configuration
    logic [POINTS_W-1:0]  n_pts;
    logic [STAGE_W-1:0]   last_pt;
    logic [PATTERN_W-1:0] dflt_pat, cool_pat;

    assign n_pts    = (points_reg > POINTS_W'(MAX_POINTS)) ? POINTS_W'(MAX_POINTS)
                                                           : points_reg;
    assign last_pt  = STAGE_W'(n_pts - 4'd1);
    assign dflt_pat = pair_reg[7:0];
    assign cool_pat = pair_reg[15:8];

    // Sequencer and datapath registers
    pc_t                  pc_reg, pc_next;
    logic [TEMP_W-1:0]    temp_reg, temp_next;
    logic                 ok_reg, ok_next;
    logic [STAGE_W-1:0]   s_reg, s_next;
    logic                 started_reg, started_next;
    logic [STAGE_W-1:0]   stage_reg, stage_next;
    logic                 fan_on_reg, fan_on_next;
    logic [FCW-1:0]       fail_reg, fail_next;
    logic [PATTERN_W-1:0] pattern_reg, pattern_next;
    logic [TARGET_W-1:0]  target_reg, target_next;
    event_t               ev_reg, ev_next;
    logic                 ap_reg, ap_next;
    logic                 at_reg, at_next;

    // Output register
    logic                 ovalid_reg, ovalid_next;
    logic [PATTERN_W-1:0] opat_reg, opat_next;
    logic [TARGET_W-1:0]  otgt_reg, otgt_next;
    logic [STAGE_W-1:0]   ostage_reg, ostage_next;
    logic                 orun_reg, orun_next;
    event_t               oev_reg, oev_next;
    logic                 oap_reg, oap_next;
    logic                 oat_reg, oat_next;

    uword_t ctl;
    assign ctl = ucode(pc_reg);

    // Stage walk compares, one step per cycle
    logic [STAGE_W-1:0] s_up;
    logic [TEMP_W-1:0]  up_next_thr, up_cur_thr;
    logic               climb_ok, drop_ok, step_taken, out_free, take;

    assign s_up        = s_reg + 3'd1;
    assign up_next_thr = byte_sel(curve_up_reg, s_up);
    assign up_cur_thr  = byte_sel(curve_up_reg, s_reg);
    assign climb_ok    = (({1'b0, s_reg} + 4'd1) < n_pts) && (temp_reg >= up_next_thr);
    assign drop_ok     = (s_reg != '0) &&
                         (({1'b0, temp_reg} + {4'b0, hyst_reg}) <= {1'b0, up_cur_thr});
    assign step_taken  = ((ctl.op == OP_CLIMB) && climb_ok) ||
                         ((ctl.op == OP_DESCEND) && drop_ok);
    assign out_free    = !ovalid_reg || result.ready;

    // Stage load values for the walked stage
    logic [7:0]          tgt_byte;
    logic                tgt_ok;
    logic [PATTERN_W-1:0] pat_byte;

    assign tgt_byte = byte_sel(curve_tgt_reg, s_reg);
    assign pat_byte = byte_sel(curve_pat_reg, s_reg);
    assign tgt_ok   = (tgt_byte >= 8'(TARGET_MIN)) && (tgt_byte <= 8'(TARGET_MAX));

    // Jump condition
    always_comb
    begin
        unique case (ctl.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_INPUT: take = !poll.valid;
            C_NOT_OK:   take = !ok_reg;
            C_NO_CURVE: take = (n_pts == '0);
            C_STEP:     take = step_taken;
            C_OUT_FREE: take = out_free;
            default:    take = 1'b1;
        endcase
        pc_next = take ? ctl.target : pc_reg + 4'd1;
    end

    // Datapath control
    logic want_on;
    logic [FCW-1:0] fail_inc;

    assign want_on  = fan_on_reg ? (temp_reg > off_reg) : (temp_reg >= on_reg);
    assign fail_inc = (fail_reg < FAIL_MAX) ? fail_reg + FCW'(1) : fail_reg;

    always_comb
    begin
        temp_next    = temp_reg;
        ok_next      = ok_reg;
        s_next       = s_reg;
        started_next = started_reg;
        stage_next   = stage_reg;
        fan_on_next  = fan_on_reg;
        fail_next    = fail_reg;
        pattern_next = pattern_reg;
        target_next  = target_reg;
        ev_next      = ev_reg;
        ap_next      = ap_reg;
        at_next      = at_reg;
        ovalid_next  = ovalid_reg && !result.ready;
        opat_next    = opat_reg;
        otgt_next    = otgt_reg;
        ostage_next  = ostage_reg;
        orun_next    = orun_reg;
        oev_next     = oev_reg;
        oap_next     = oap_reg;
        oat_next     = oat_reg;

        unique case (ctl.op)
            OP_NOP: ;
            OP_LATCH:
            begin
                temp_next = poll.temperature;
                ok_next   = poll.reading_ok;
            end
            OP_CLAMP:
            begin
                if (!started_reg)
                    s_next = '0;
                else if ({1'b0, stage_reg} >= n_pts)
                    s_next = last_pt;
                else
                    s_next = stage_reg;
            end
            OP_CLIMB:
            begin
                if (climb_ok)
                    s_next = s_up;
            end
            OP_DESCEND:
            begin
                if (drop_ok)
                    s_next = s_reg - 3'd1;
            end
            OP_CURVE_UPD:
            begin
                fail_next = '0;
                ap_next   = 1'b0;
                at_next   = 1'b0;
                ev_next   = EV_HOLD;
                if (!started_reg || (s_reg != stage_reg))
                begin
                    started_next = 1'b1;
                    ev_next      = started_reg ? EV_CHANGE : EV_INIT;
                    ap_next      = 1'b1;
                    stage_next   = s_reg;
                    pattern_next = pat_byte;
                    target_next  = tgt_ok ? tgt_byte[TARGET_W-1:0] : '0;
                    at_next      = tgt_ok;
                end
            end
            OP_THRESH_UPD:
            begin
                fail_next = '0;
                at_next   = 1'b0;
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    fan_on_next  = (temp_reg >= on_reg);
                    pattern_next = (temp_reg >= on_reg) ? cool_pat : dflt_pat;
                    stage_next   = '0;
                    ev_next      = EV_INIT;
                    ap_next      = 1'b1;
                end
                else if (want_on != fan_on_reg)
                begin
                    fan_on_next  = want_on;
                    pattern_next = want_on ? cool_pat : dflt_pat;
                    ev_next      = EV_TOGGLE;
                    ap_next      = 1'b1;
                end
                else
                begin
                    ev_next = EV_HOLD;
                    ap_next = 1'b0;
                end
            end
            OP_FAIL_UPD:
            begin
                ev_next = EV_NONE;
                ap_next = 1'b0;
                at_next = 1'b0;
                if (started_reg)
                begin
                    fail_next = fail_inc;
                    if ((fail_inc >= FAIL_MAX) && !fan_on_reg)
                    begin
                        fan_on_next  = 1'b1;
                        pattern_next = cool_pat;
                        ev_next      = EV_FAIL;
                        ap_next      = 1'b1;
                    end
                end
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    opat_next   = pattern_reg;
                    otgt_next   = (n_pts != '0) ? target_reg : '0;
                    ostage_next = stage_reg;
                    orun_next   = fan_on_reg;
                    oev_next    = ev_reg;
                    oap_next    = ap_reg;
                    oat_next    = at_reg;
                end
            end
            default: ;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= S_WAIT;
            started_reg <= 1'b0;
            stage_reg   <= '0;
            fan_on_reg  <= 1'b0;
            fail_reg    <= '0;
            pattern_reg <= PAIR_RST[7:0];
            target_reg  <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            pc_reg      <= pc_next;
            started_reg <= started_next;
            stage_reg   <= stage_next;
            fan_on_reg  <= fan_on_next;
            fail_reg    <= fail_next;
            pattern_reg <= pattern_next;
            target_reg  <= target_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        temp_reg   <= temp_next;
        ok_reg     <= ok_next;
        s_reg      <= s_next;
        ev_reg     <= ev_next;
        ap_reg     <= ap_next;
        at_reg     <= at_next;
        opat_reg   <= opat_next;
        otgt_reg   <= otgt_next;
        ostage_reg <= ostage_next;
        orun_reg   <= orun_next;
        oev_reg    <= oev_next;
        oap_reg    <= oap_next;
        oat_reg    <= oat_next;
    end

    // Ports
    assign poll.ready                = (ctl.op == OP_LATCH);
    assign result.valid              = ovalid_reg;
    assign result.fan_pattern        = opat_reg;
    assign result.target_temperature = otgt_reg;
    assign result.stage              = ostage_reg;
    assign result.fan_running        = orun_reg;
    assign result.event_res          = oev_reg;
    assign result.apply_pattern      = oap_reg;
    assign result.apply_target       = oat_reg;

    // Checks
    a_poll_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
        poll.valid && poll.ready |=> pc_reg == S_CHECK_OK)
        else $error("accepted poll did not start the program");

    a_stage_in_curve: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op == OP_CURVE_UPD |=> {1'b0, stage_reg} < n_pts)
        else $error("curve stage beyond point count");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op == OP_EMIT && out_free |=> ovalid_reg && pc_reg == S_WAIT)
        else $error("emit step did not load the output register");

    a_fail_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        fail_reg <= FAIL_MAX)
        else $error("failure counter above limit");

    a_fail_safe_sets_fan: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op == OP_FAIL_UPD && started_reg && !fan_on_reg && fail_inc >= FAIL_MAX
        |=> fan_on_reg && ev_reg == EV_FAIL)
        else $error("fail safe did not force the fan on");

endmodule
